// ===== design/stbs_pkg.sv =====
// Shared constants for the sorted timestamp bracket search.
// Item mode codes, result status codes and field widths; no dependencies.
`timescale 1ns / 1ps

package stbs_pkg;

    localparam int KEY_W    = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 10;

    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam mode_t MODE_CLEAR  = 2'd0;
    localparam mode_t MODE_APPEND = 2'd1;
    localparam mode_t MODE_QUERY  = 2'd2;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_RANGE = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

endpackage

// ===== design/stbs_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/sorted_timestamp_bracket_search.sv =====
// Top level of the sorted timestamp bracket search.
// Depends on stbs_pkg and stbs_ram.
`timescale 1ns / 1ps

// Usage:
//   Input channel s_valid/s_ready carries s_mode and s_key; result channel
//   m_valid/m_ready carries m_status and m_index. Every input transfer gives
//   exactly one result transfer, in order.
//   Mode clear empties the table, mode append writes s_key at the next free
//   entry (status full and no write when the table holds DEPTH entries),
//   mode query returns the index of the entry that brackets s_key.
//   Clear, append and the unused mode go from the transfer straight to the
//   result state, and so does a query on an empty table; any other query
//   reads the first and last entries and then probes the table memory once
//   per cycle, at most about log2(DEPTH) probes. The table memory has a
//   single read port, so the search makes one probe at a time.
//   One item is processed at a time; s_ready is high whenever no item is in
//   flight, also while a finished result waits in the output register.
//   Reset (aresetn low, synchronous) empties the table and drops any result.
//   When the receiver stalls, the result is held in the output register and
//   a further finished item waits until that register is taken.

module sorted_timestamp_bracket_search
    import stbs_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [MODE_W-1:0]   s_mode,
    input  logic [KEY_W-1:0]    s_key,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [IDX_W-1:0]    m_index
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FIRST  = 3'd1;
    localparam logic [2:0] S_LAST   = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_PROBE  = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [CW-1:0]       upper_reg, upper_next;
    logic [CW-1:0]       lower_reg, lower_next;
    logic [CW-1:0]       guess_reg, guess_next;
    status_t             res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_index_reg, res_index_next;
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [IDX_W-1:0]    m_index_reg, m_index_next;

    logic                s_fire;
    logic                out_free;
    logic                ram_we;
    logic [AW-1:0]       ram_raddr;
    logic [KEY_W-1:0]    rd_data;

    logic                probe_eq;
    logic                probe_lt;
    logic [CW-1:0]       upper_try;
    logic [CW-1:0]       lower_try;
    logic [CW-1:0]       guess_try;
    logic [CW-1:0]       guess_first;

    stbs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_time_store (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (AW'(count_reg)),
        .wr_data (s_key),
        .rd_addr (ram_raddr),
        .rd_data (rd_data)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign ram_we   = s_fire && (s_mode == MODE_APPEND) && (count_reg != FULL_COUNT);

    assign probe_eq    = (rd_data == key_reg);
    assign probe_lt    = (key_reg < rd_data);
    assign upper_try   = probe_lt ? guess_reg : upper_reg;
    assign lower_try   = probe_lt ? lower_reg : guess_reg;
    assign guess_try   = ((upper_try - lower_try) >> 1) + lower_try;
    assign guess_first = count_reg >> 1;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        key_next        = key_reg;
        upper_next      = upper_reg;
        lower_next      = lower_reg;
        guess_next      = guess_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_index_next    = m_index_reg;
        ram_raddr       = AW'(guess_reg);

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    key_next        = s_key;
                    res_status_next = STATUS_OK;
                    res_index_next  = '0;
                    state_next      = S_RESULT;
                    unique case (s_mode)
                        MODE_CLEAR: begin
                            count_next = '0;
                        end
                        MODE_APPEND: begin
                            if (count_reg == FULL_COUNT) begin
                                res_status_next = STATUS_FULL;
                            end else begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_QUERY: begin
                            if (count_reg == '0) begin
                                res_status_next = STATUS_RANGE;
                            end else begin
                                state_next = S_FIRST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FIRST: begin
                ram_raddr  = '0;
                state_next = S_LAST;
            end
            S_LAST: begin
                ram_raddr = AW'(count_reg - 1'b1);
                if (key_reg < rd_data) begin
                    res_status_next = STATUS_RANGE;
                    state_next      = S_RESULT;
                end else begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                ram_raddr = AW'(guess_first);
                if (key_reg > rd_data) begin
                    res_status_next = STATUS_RANGE;
                    state_next      = S_RESULT;
                end else begin
                    upper_next = count_reg;
                    lower_next = '0;
                    guess_next = guess_first;
                    if (guess_first == '0) begin
                        res_index_next = '0;
                        state_next     = S_RESULT;
                    end else begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                ram_raddr = AW'(guess_try);
                if (probe_eq) begin
                    res_index_next = IDX_W'(guess_reg);
                    state_next     = S_RESULT;
                end else begin
                    upper_next = upper_try;
                    lower_next = lower_try;
                    guess_next = guess_try;
                    if (guess_try == upper_try || guess_try == lower_try) begin
                        res_index_next = IDX_W'(guess_try);
                        state_next     = S_RESULT;
                    end
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_index_next  = res_index_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg        <= key_next;
        upper_reg      <= upper_next;
        lower_reg      <= lower_next;
        guess_reg      <= guess_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        m_status_reg   <= m_status_next;
        m_index_reg    <= m_index_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_index  = m_index_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("entry count exceeds table depth");

    a_probe_window: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_PROBE |-> lower_reg < guess_reg && guess_reg < upper_reg
            && upper_reg <= count_reg)
        else $error("search probe outside its window");

    a_index_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |-> m_index == '0)
        else $error("nonzero index on a failed transfer");

endmodule
